// File: src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/dls_pkg.sv
package dls_pkg;

  localparam int DUTY_DIVISOR = 15;

  localparam int LEN_W      = 16;
  localparam int BPS_W      = 16;
  localparam int RATE_W     = 13;
  localparam int ELAPSED_W  = 14;
  localparam int BTIME_W    = 9;
  localparam int DIV_W      = 20;
  // wide enough for length * DUTY_DIVISOR
  localparam int DIVISOR_W  = LEN_W + $clog2(DUTY_DIVISOR + 1);
  localparam int DIV_CNT_W  = 5;
  localparam int PERIOD_W   = 14;
  localparam int MUL10_W    = ELAPSED_W + 4;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [DIV_W-1:0]     DUTY_NUM    = DIV_W'(1000000);
  localparam logic [DIV_W-1:0]     PERIOD_NUM  = DIV_W'(10000);
  localparam logic [DIVISOR_W-1:0] DUTY_MUL    = DIVISOR_W'(DUTY_DIVISOR);
  localparam logic [RATE_W-1:0]    RATE_MAX    = {RATE_W{1'b1}};
  localparam logic [LEN_W-1:0]     LEN_MIN     = LEN_W'(10);
  localparam logic [LEN_W-1:0]     LEN_MAX     = LEN_W'(500);
  localparam logic [LEN_W-1:0]     LEN_OC_MAX  = LEN_W'(100);
  localparam logic [LEN_W-1:0]     LEN_RESET   = LEN_W'(100);
  localparam logic [BPS_W-1:0]     BPS_RESET   = BPS_W'(1);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST    = DIV_CNT_W'(DIV_W - 1);

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_LENGTH = 2'd1;
  localparam logic [1:0] REG_RATE   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DUTY,
    ST_PERIOD,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                 enable;
    logic [LEN_W-1:0]     length;
    logic [BPS_W-1:0]     bps;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_W-1:0]     quotient;
  } div_rsp_t;

endpackage

// File: src/dls_regs.sv
module dls_regs
  import dls_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 1'b0;
      cfg.length <= LEN_RESET;
      cfg.bps    <= BPS_RESET;
    end else if (wr_en) begin
      priority case (reg_idx)
        REG_ENABLE: cfg.enable <= pwdata[0];
        REG_LENGTH: cfg.length <= pwdata[LEN_W-1:0];
        REG_RATE:   cfg.bps    <= pwdata[BPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority case (reg_idx)
      REG_ENABLE: prdata = {{(DATA_W-1){1'b0}}, cfg.enable};
      REG_LENGTH: prdata = {{(DATA_W-LEN_W){1'b0}}, cfg.length};
      REG_RATE:   prdata = {{(DATA_W-BPS_W){1'b0}}, cfg.bps};
      default:    prdata = '0;
    endcase
  end

endmodule

// File: src/dls_div.sv
module dls_div
  import dls_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  // restoring divider, one quotient bit per cycle
  logic [DIV_W-1:0]     dvd;
  logic [DIVISOR_W-1:0] divisor;
  logic [DIVISOR_W-1:0] rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DIVISOR_W:0]   rem_sh;
  logic                 fits;

  assign rem_sh = {rem, dvd[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      rem <= fits ? DIVISOR_W'(rem_sh - {1'b0, divisor}) : rem_sh[DIVISOR_W-1:0];
      dvd <= {dvd[DIV_W-2:0], fits};
    end else if (req.start) begin
      dvd     <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

// File: src/duty_limited_burst_scheduler.sv
// Burst slot scheduler, one input item per millisecond tick.
// Input channel: in_valid/in_stall with overcurrent_flag. Output channel:
// out_valid/out_stall with fire_burst, clear_overcurrent, burst_time_us
// and effective_rate; every tick yields exactly one result item.
// Registers (APB, 32-bit): 0x0 burst_enable, 0x4 burst_length_us,
// 0x8 bursts_per_second. Write them only while no tick is in flight.
// The tick makes two passes through one 20-step restoring divider:
// 1000000/(length*DUTY_DIVISOR) for the duty cap, then 10000/rate for
// the slot period, and the result is then loaded into the output
// register. in_stall is high from the accepting edge until the result is
// loaded, so the block takes no new tick while one is in flight.
// A finished result waits in the output register; while out_stall holds
// it, the block stays in its finish step and the next tick is held off.
// Reset: enable 0, length 100, rate 1, elapsed count saturated so the
// first enabled tick opens a slot; no result is pending.
module duty_limited_burst_scheduler
  import dls_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                overcurrent_flag,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                fire_burst,
  output logic                clear_overcurrent,
  output logic [BTIME_W-1:0]  burst_time_us,
  output logic [RATE_W-1:0]   effective_rate
);

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;
  state_t   state, state_next;

  logic [ELAPSED_W-1:0] elapsed;
  logic                 trip;
  logic [RATE_W-1:0]    rate;
  logic [PERIOD_W-1:0]  period;

  logic                 in_acc;
  logic                 load_out;
  logic [LEN_W-1:0]     len_nz;
  logic [DIVISOR_W-1:0] duty_den;
  logic [RATE_W-1:0]    cap;
  logic [RATE_W-1:0]    rate_min;
  logic [RATE_W-1:0]    rate_calc;
  logic [MUL10_W-1:0]   elapsed_x10;
  logic                 slot;
  logic                 oc_block;
  logic [BTIME_W-1:0]   len_clamped;

  dls_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dls_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // floor(floor(a/b)/c) == floor(a/(b*c)), so the cap takes one pass
  assign len_nz   = (cfg.length == '0) ? LEN_W'(1) : cfg.length;
  assign duty_den = DIVISOR_W'(len_nz) * DUTY_MUL;

  // duty cap saturates, rate = max(1, min(bps, cap))
  assign cap       = (div_rsp.quotient[DIV_W-1:RATE_W] != '0) ? RATE_MAX
                                                               : div_rsp.quotient[RATE_W-1:0];
  assign rate_min  = (cfg.bps > {{(BPS_W-RATE_W){1'b0}}, cap}) ? cap : cfg.bps[RATE_W-1:0];
  assign rate_calc = (rate_min == '0) ? RATE_W'(1) : rate_min;

  assign elapsed_x10 = ({4'b0, elapsed} << 3) + ({4'b0, elapsed} << 1);
  assign slot        = cfg.enable && (elapsed_x10 >= {{(MUL10_W-PERIOD_W){1'b0}}, period});
  assign oc_block    = trip && (cfg.length > LEN_OC_MAX);

  always_comb begin
    if (cfg.length < LEN_MIN) begin
      len_clamped = BTIME_W'(LEN_MIN);
    end else if (cfg.length > LEN_MAX) begin
      len_clamped = BTIME_W'(LEN_MAX);
    end else begin
      len_clamped = cfg.length[BTIME_W-1:0];
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = DUTY_NUM;
    div_req.divisor  = duty_den;
    load_out         = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          div_req.start = 1'b1;
          state_next    = ST_DUTY;
        end
      end
      ST_DUTY: begin
        div_req.dividend = PERIOD_NUM;
        div_req.divisor  = {{(DIVISOR_W-RATE_W){1'b0}}, rate_calc};
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          state_next    = ST_PERIOD;
        end
      end
      ST_PERIOD: begin
        if (div_rsp.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed   <= {ELAPSED_W{1'b1}};
      out_valid <= 1'b0;
    end else begin
      if (in_acc && elapsed != {ELAPSED_W{1'b1}}) begin
        elapsed <= elapsed + ELAPSED_W'(1);
      end else if (load_out && slot) begin
        elapsed <= '0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      trip <= overcurrent_flag;
    end
    if (state == ST_DUTY && div_rsp.done) begin
      rate <= rate_calc;
    end
    if (state == ST_PERIOD && div_rsp.done) begin
      period <= div_rsp.quotient[PERIOD_W-1:0];
    end
    if (load_out) begin
      fire_burst        <= slot && !oc_block;
      clear_overcurrent <= slot && oc_block;
      burst_time_us     <= len_clamped;
      effective_rate    <= rate;
    end
  end

endmodule

// File: src/dls_checker.sv
`include "assert_macros.svh"

module dls_checker
  import dls_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               fire_burst,
  input logic               clear_overcurrent,
  input logic [BTIME_W-1:0] burst_time_us,
  input logic [RATE_W-1:0]  effective_rate
);

  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `ASSERT_CLK(a_busy_after_accept, clk, rst, in_valid && !in_stall |=> in_stall, "second item taken during a tick")
  `ASSERT_CLK(a_flags_exclusive, clk, rst, out_valid |-> !(fire_burst && clear_overcurrent), "fire and clear together")
  `ASSERT_CLK(a_time_range, clk, rst, out_valid |-> (burst_time_us >= BTIME_W'(10) && burst_time_us <= BTIME_W'(500)), "burst time out of range")
  `ASSERT_CLK(a_rate_nonzero, clk, rst, out_valid |-> effective_rate != '0, "zero effective rate")

endmodule

bind duty_limited_burst_scheduler dls_checker u_dls_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .fire_burst        (fire_burst),
  .clear_overcurrent (clear_overcurrent),
  .burst_time_us     (burst_time_us),
  .effective_rate    (effective_rate)
);
